// ===== src/cbfp_pkg.sv =====
// shared types, constants and the crc step for the byte frame parser
`default_nettype none

package cbfp_pkg;

   // largest accepted payload in bytes
   localparam int MAX_PAYLOAD = 8;

   // token queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // crc-16 modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // register indexes of the csr port
   localparam logic CSR_HEAD = 1'b0;
   localparam logic CSR_TAIL = 1'b1;

   // what a classified byte means to the back end
   typedef enum logic [2:0] {
      TOK_TYPE,
      TOK_LEN_BAD,
      TOK_LEN_OK,
      TOK_DATA,
      TOK_CRC_HI,
      TOK_CRC_LO,
      TOK_TAIL
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   data;
      logic         tail_ok;
   } token_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_GOOD,
      ST_BAD_LEN,
      ST_CRC_ERR,
      ST_TAIL_ERR
   } status_type;

   // frame delimiters from the csr port
   typedef struct packed {
      logic [7:0] head_value;
      logic [7:0] tail_value;
   } cfg_type;

   // one byte through the reflected crc, lsb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/cbfp_front.sv =====
// front end: frame phase tracking and byte classification into tokens
`default_nettype none

module cbfp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cbfp_pkg::cfg_type   cfg,
   input  wire logic                byte_valid,
   input  wire logic [7:0]          byte_data,
   output logic                     tok_push,
   output cbfp_pkg::token_type      tok
);
   import cbfp_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_TYPE,
      PH_LENHI,
      PH_LENLO,
      PH_DATA,
      PH_CRCHI,
      PH_CRCLO,
      PH_TAIL
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       hi_bad_ff, hi_bad_in;
   logic [3:0] len_ff, len_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [3:0] cnt_next;
   logic       len_bad;

   assign cnt_next = cnt_ff + 4'd1;
   assign len_bad  = hi_bad_ff || (byte_data > 8'(MAX_PAYLOAD));

   // next phase and token for an accepted byte
   always_comb begin
      phase_in    = phase_ff;
      hi_bad_in   = hi_bad_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      tok_push    = 1'b0;
      tok.kind    = TOK_TYPE;
      tok.data    = byte_data;
      tok.tail_ok = (byte_data == cfg.tail_value);
      if (byte_valid) begin
         case (phase_ff)
            PH_HUNT: begin
               if (byte_data == cfg.head_value) phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               tok_push = 1'b1;
               tok.kind = TOK_TYPE;
               phase_in = PH_LENHI;
            end
            PH_LENHI: begin
               hi_bad_in = (byte_data != 8'h00);
               phase_in  = PH_LENLO;
            end
            PH_LENLO: begin
               tok_push = 1'b1;
               if (len_bad) begin
                  tok.kind = TOK_LEN_BAD;
                  phase_in = PH_HUNT;
               end else begin
                  tok.kind = TOK_LEN_OK;
                  len_in   = byte_data[3:0];
                  cnt_in   = 4'd0;
                  phase_in = (byte_data == 8'h00) ? PH_CRCHI : PH_DATA;
               end
            end
            PH_DATA: begin
               tok_push = 1'b1;
               tok.kind = TOK_DATA;
               cnt_in   = cnt_next;
               if (cnt_next >= len_ff) phase_in = PH_CRCHI;
            end
            PH_CRCHI: begin
               tok_push = 1'b1;
               tok.kind = TOK_CRC_HI;
               phase_in = PH_CRCLO;
            end
            PH_CRCLO: begin
               tok_push = 1'b1;
               tok.kind = TOK_CRC_LO;
               phase_in = PH_TAIL;
            end
            PH_TAIL: begin
               tok_push = 1'b1;
               tok.kind = TOK_TAIL;
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // phase and length bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         hi_bad_ff <= 1'b0;
         len_ff    <= 4'd0;
         cnt_ff    <= 4'd0;
      end else begin
         phase_ff  <= phase_in;
         hi_bad_ff <= hi_bad_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/cbfp_queue.sv =====
// short token fifo between front and back ends
`default_nettype none

module cbfp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cbfp_pkg::token_type push_tok,
   output logic                     ready,
   input  wire logic                pop,
   output logic                     head_valid,
   output cbfp_pkg::token_type      head_tok
);
   import cbfp_pkg::*;

   token_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign ready      = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_tok   = entry_ff[rd_ptr_ff];
   assign do_push    = push && ready;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // token storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_tok;
   end

endmodule

`default_nettype wire

// ===== src/cbfp_back.sv =====
// back end: payload capture, crc check and result register
`default_nettype none

module cbfp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                tok_valid,
   input  wire cbfp_pkg::token_type tok,
   output logic                     tok_pop,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [1:0]               rsp_tuser,   // status
   output logic [79:0]              rsp_tdata    // frame_type, data_len, payload, zero pad
);
   import cbfp_pkg::*;

   logic [7:0]  kind_ff, kind_in;
   logic [3:0]  len_ff, len_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] payload_ff, payload_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic        match_ff, match_in;

   logic        out_valid_ff, out_valid_in;
   status_type  out_status_ff, out_status_in;
   logic [7:0]  out_type_ff, out_type_in;
   logic [3:0]  out_len_ff, out_len_in;
   logic [63:0] out_payload_ff, out_payload_in;

   logic        emits;
   logic        out_free;

   assign emits    = (tok.kind == TOK_LEN_BAD) || (tok.kind == TOK_TAIL);
   assign out_free = !out_valid_ff || rsp_tready;
   assign tok_pop  = tok_valid && (!emits || out_free);

   // token execution and result build
   always_comb begin
      kind_in        = kind_ff;
      len_in         = len_ff;
      idx_in         = idx_ff;
      payload_in     = payload_ff;
      crc_in         = crc_ff;
      crc_hi_in      = crc_hi_ff;
      match_in       = match_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_status_in  = out_status_ff;
      out_type_in    = out_type_ff;
      out_len_in     = out_len_ff;
      out_payload_in = out_payload_ff;
      if (tok_pop) begin
         case (tok.kind)
            TOK_TYPE: begin
               kind_in = tok.data;
            end
            TOK_LEN_BAD: begin
               out_valid_in   = 1'b1;
               out_status_in  = ST_BAD_LEN;
               out_type_in    = 8'h00;
               out_len_in     = 4'd0;
               out_payload_in = 64'd0;
            end
            TOK_LEN_OK: begin
               len_in     = tok.data[3:0];
               idx_in     = 3'd0;
               payload_in = 64'd0;
               crc_in     = CRC_INIT;
            end
            TOK_DATA: begin
               payload_in[{idx_ff, 3'b000} +: 8] = tok.data;
               crc_in = crc16_byte(crc_ff, tok.data);
               idx_in = idx_ff + 3'd1;
            end
            TOK_CRC_HI: begin
               crc_hi_in = tok.data;
            end
            TOK_CRC_LO: begin
               match_in = ({crc_hi_ff, tok.data} == crc_ff);
            end
            TOK_TAIL: begin
               out_valid_in   = 1'b1;
               out_status_in  = !match_ff ? ST_CRC_ERR : (tok.tail_ok ? ST_GOOD : ST_TAIL_ERR);
               out_type_in    = kind_ff;
               out_len_in     = len_ff;
               out_payload_in = payload_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= 8'h00;
         len_ff       <= 4'd0;
         idx_ff       <= 3'd0;
         payload_ff   <= 64'd0;
         crc_ff       <= CRC_INIT;
         crc_hi_ff    <= 8'h00;
         match_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         kind_ff      <= kind_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         payload_ff   <= payload_in;
         crc_ff       <= crc_in;
         crc_hi_ff    <= crc_hi_in;
         match_ff     <= match_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      out_status_ff  <= out_status_in;
      out_type_ff    <= out_type_in;
      out_len_ff     <= out_len_in;
      out_payload_ff <= out_payload_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {4'h0, out_payload_ff, out_len_ff, out_type_ff};

endmodule

`default_nettype wire

// ===== src/crc16_byte_frame_parser_core.sv =====
// top level of the byte deframer with crc-16 check
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata[7:0] rx_byte
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tuser status, rsp_tdata type/len/payload
//   csr      in   csr_we                 csr_index, csr_wdata
//
// one byte is accepted per cycle while req_tready is high; the front phase tracker
// classifies it and the back end executes it out of a two-entry token queue.
// the result register drives rsp once the tail or bad length token is executed.
// reset is synchronous and returns the parser to head hunting with default delimiters.
// req_tready drops when a result waits on rsp, the next result token sits at the queue head and
// one more token of any kind is queued behind it; until then bytes keep flowing.
`default_nettype none

module crc16_byte_frame_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,    // status
   output logic [79:0]      rsp_tdata,    // frame_type, data_len, payload, zero pad
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import cbfp_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      q_ready;
   logic      byte_valid;
   logic      tok_push;
   token_type tok;
   logic      head_valid;
   token_type head_tok;
   logic      tok_pop;

   // delimiter registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEAD: cfg_in.head_value = csr_wdata;
            CSR_TAIL: cfg_in.tail_value = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_value <= 8'hAA;
         cfg_ff.tail_value <= 8'h55;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = q_ready;
   assign byte_valid = req_tvalid && q_ready;

   cbfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .byte_valid (byte_valid),
      .byte_data  (req_tdata),
      .tok_push   (tok_push),
      .tok        (tok)
   );

   cbfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (tok_push),
      .push_tok   (tok),
      .ready      (q_ready),
      .pop        (tok_pop),
      .head_valid (head_valid),
      .head_tok   (head_tok)
   );

   cbfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (head_valid),
      .tok        (head_tok),
      .tok_pop    (tok_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // front never pushes a token the queue cannot take
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      tok_push |-> q_ready)
      else $error("token pushed into a full queue");

   // a bad length result carries no frame contents
   a_bad_len_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_BAD_LEN)) |-> (rsp_tdata == 80'd0))
      else $error("bad length result with nonzero fields");

   // reported length never exceeds the payload limit
   a_len_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:8] <= 4'(MAX_PAYLOAD)))
      else $error("result length above limit");

   // back end never drops a waiting result to take a new one
   a_no_result_loss: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && tok_pop) |->
         !((head_tok.kind == TOK_LEN_BAD) || (head_tok.kind == TOK_TAIL)))
      else $error("result token executed while output stalled");

endmodule

`default_nettype wire

// ===== tb/sv/tb_crc16_byte_frame_parser_core.sv =====
// testbench for the byte frame parser: random and directed byte streams, results checked in order
`timescale 1ns / 100ps

module tb_crc16_byte_frame_parser_core;
   import cbfp_pkg::*;

   localparam int          CLK_HALF      = 5;
   localparam int          RESET_CYCLES  = 7;
   localparam int          GAP_MAX       = 19;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          QUIET_LIMIT   = 2000;
   localparam int          PHASE_BYTES   = 140;
   localparam logic [7:0]  DEFAULT_HEAD  = 8'hAA;
   localparam logic [7:0]  DEFAULT_TAIL  = 8'h55;

   // parser position as the predictor tracks it
   typedef enum logic [2:0] {
      SG_HUNT, SG_TYPE, SG_LEN_MSB, SG_LEN_LSB, SG_DATA, SG_CRC_MSB, SG_CRC_LSB, SG_TAIL
   } parse_stage_type;

   // ways a generated frame can be spoiled
   typedef enum {
      FL_NONE, FL_CRC, FL_TAIL, FL_BOTH, FL_LEN_MSB, FL_LEN_LSB
   } frame_flaw_type;

   typedef struct {
      status_type  status;
      logic [7:0]  ftype;
      logic [3:0]  len;
      logic [63:0] pdata;
   } frame_result_type;

   // predicts frame results from accepted bytes and checks them in order
   class frame_checker;
      frame_result_type frames_due[$];
      int               errors;
      logic [7:0]       head_byte;
      logic [7:0]       tail_byte;
      parse_stage_type  stage;
      logic [7:0]       ftype;
      logic             len_over;
      logic [3:0]       plen;
      logic [3:0]       got;
      logic [63:0]      pdata;
      logic [15:0]      crc_acc;
      logic [7:0]       crc_msb;
      logic             crc_good;

      function new();
         errors    = 0;
         head_byte = DEFAULT_HEAD;
         tail_byte = DEFAULT_TAIL;
         stage     = SG_HUNT;
         ftype     = '0;
         len_over  = 1'b0;
         plen      = '0;
         got       = '0;
         pdata     = '0;
         crc_acc   = CRC_INIT;
         crc_msb   = '0;
         crc_good  = 1'b0;
      endfunction

      // bit-serial form of the reflected crc
      static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
         logic fb;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb) begin
               c = c ^ CRC_POLY;
            end
         end
         return c;
      endfunction

      static function logic [15:0] crc_over(logic [63:0] d, int n);
         logic [15:0] c;
         c = CRC_INIT;
         for (int i = 0; i < n; i++) begin
            c = crc_step(c, d[8*i +: 8]);
         end
         return c;
      endfunction

      function void load_delimiters(logic [7:0] h, logic [7:0] t);
         head_byte = h;
         tail_byte = t;
      endfunction

      function int pending();
         return frames_due.size();
      endfunction

      function void post(status_type s, logic [7:0] ty, logic [3:0] ln, logic [63:0] pl);
         frame_result_type r;
         r.status = s;
         r.ftype  = ty;
         r.len    = ln;
         r.pdata  = pl;
         frames_due.push_back(r);
      endfunction

      // one accepted request byte
      function void take_byte(logic [7:0] b);
         case (stage)
            SG_HUNT: begin
               if (b == head_byte) begin
                  stage = SG_TYPE;
               end
            end
            SG_TYPE: begin
               ftype = b;
               stage = SG_LEN_MSB;
            end
            SG_LEN_MSB: begin
               len_over = (b != 8'h00);
               stage    = SG_LEN_LSB;
            end
            SG_LEN_LSB: begin
               if (len_over || b > MAX_PAYLOAD) begin
                  post(ST_BAD_LEN, '0, '0, '0);
                  stage = SG_HUNT;
               end else begin
                  plen    = b[3:0];
                  got     = '0;
                  pdata   = '0;
                  crc_acc = CRC_INIT;
                  stage   = (plen == 0) ? SG_CRC_MSB : SG_DATA;
               end
            end
            SG_DATA: begin
               pdata[got[2:0]*8 +: 8] = b;
               crc_acc = crc_step(crc_acc, b);
               got     = got + 4'd1;
               if (got >= plen) begin
                  stage = SG_CRC_MSB;
               end
            end
            SG_CRC_MSB: begin
               crc_msb = b;
               stage   = SG_CRC_LSB;
            end
            SG_CRC_LSB: begin
               crc_good = ({crc_msb, b} == crc_acc);
               stage    = SG_TAIL;
            end
            default: begin
               // crc mismatch wins over a wrong tail
               if (!crc_good) begin
                  post(ST_CRC_ERR, ftype, plen, pdata);
               end else if (b != tail_byte) begin
                  post(ST_TAIL_ERR, ftype, plen, pdata);
               end else begin
                  post(ST_GOOD, ftype, plen, pdata);
               end
               stage = SG_HUNT;
            end
         endcase
      endfunction

      // one accepted result against the oldest prediction
      function void check_result(logic [1:0] st, logic [79:0] td);
         frame_result_type want;
         if (frames_due.size() == 0) begin
            $error("result with none expected: status %0d tdata %h", st, td);
            errors++;
            return;
         end
         want = frames_due.pop_front();
         if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            errors++;
         end
         if (td[7:0] !== want.ftype) begin
            $error("frame_type: expected %h, got %h", want.ftype, td[7:0]);
            errors++;
         end
         if (td[11:8] !== want.len) begin
            $error("data_len: expected %0d, got %0d", want.len, td[11:8]);
            errors++;
         end
         if (td[75:12] !== want.pdata) begin
            $error("payload: expected %h, got %h", want.pdata, td[75:12]);
            errors++;
         end
         if (td[79:76] !== 4'h0) begin
            $error("tdata pad: expected 0, got %h", td[79:76]);
            errors++;
         end
      endfunction
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'h00;   // rx_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [1:0]   rsp_tuser;            // status
   logic [79:0]  rsp_tdata;            // frame_type, data_len, payload, zero pad
   logic         csr_we     = 1'b0;
   logic         csr_index  = CSR_HEAD;
   logic [7:0]   csr_wdata  = 8'h00;

   frame_checker board;
   logic [7:0]   head_reg      = DEFAULT_HEAD;
   logic [7:0]   tail_reg      = DEFAULT_TAIL;
   bit           tx_steady     = 1'b0;
   bit           rx_steady     = 1'b0;
   bit           hold_request  = 1'b0;
   int           sent_bytes    = 0;
   int           quiet_cycles  = 0;

   crc16_byte_frame_parser_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, one long hold on demand
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
         if (hold_request) begin
            stall        = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // offer one request byte after a random gap and wait for its acceptance
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      board.take_byte(b);
      sent_bytes++;
   endtask

   // head, type, length, data, crc and tail, spoiled as asked
   task automatic send_frame(input logic [7:0] ftype, input int n, input logic [63:0] data,
                             input frame_flaw_type flaw);
      logic [15:0] crc;
      logic [15:0] flip;
      logic [7:0]  flip_tail;
      logic [7:0]  tl;
      send_byte(head_reg);
      send_byte(ftype);
      if (flaw == FL_LEN_MSB) begin
         send_byte(8'($urandom_range(1, 255)));
         send_byte(8'($urandom_range(0, 255)));
      end else if (flaw == FL_LEN_LSB) begin
         send_byte(8'h00);
         send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      end else begin
         send_byte(8'h00);
         send_byte(8'(n));
         for (int i = 0; i < n; i++) begin
            send_byte(data[8*i +: 8]);
         end
         crc = frame_checker::crc_over(data, n);
         if (flaw == FL_CRC || flaw == FL_BOTH) begin
            flip = 16'($urandom_range(1, 16'hFFFF));
            crc  = crc ^ flip;
         end
         send_byte(crc[15:8]);
         send_byte(crc[7:0]);
         tl = tail_reg;
         if (flaw == FL_TAIL || flaw == FL_BOTH) begin
            flip_tail = 8'($urandom_range(1, 255));
            tl        = tl ^ flip_tail;
         end
         send_byte(tl);
      end
   endtask

   task automatic send_random_frame();
      int             pick;
      int             n;
      logic [63:0]    data;
      frame_flaw_type flaw;
      pick = $urandom_range(0, 99);
      if (pick < 50)      flaw = FL_NONE;
      else if (pick < 63) flaw = FL_CRC;
      else if (pick < 78) flaw = FL_TAIL;
      else if (pick < 84) flaw = FL_BOTH;
      else if (pick < 92) flaw = FL_LEN_MSB;
      else                flaw = FL_LEN_LSB;
      n = $urandom_range(0, MAX_PAYLOAD);
      case ($urandom_range(0, 7))
         0:       data = '0;
         1:       data = '1;
         default: data = {$urandom, $urandom};
      endcase
      send_frame(8'($urandom_range(0, 255)), n, data, flaw);
   endtask

   // bytes the hunter drops
   task automatic send_noise(input int count);
      logic [7:0] b;
      repeat (count) begin
         do b = 8'($urandom_range(0, 255)); while (b == head_reg);
         send_byte(b);
      end
   endtask

   // a head followed by arbitrary bytes, leaving the parser anywhere
   task automatic send_broken();
      send_byte(head_reg);
      repeat ($urandom_range(1, 9)) send_byte(8'($urandom_range(0, 255)));
   endtask

   // mostly frames with random content, some noise and broken sequences
   task automatic random_traffic(input int budget);
      int spent;
      int mark;
      int pick;
      spent = 0;
      while (spent < budget) begin
         if ($urandom_range(0, 15) == 0) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
         end
         mark = sent_bytes;
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            send_random_frame();
         end else if (pick < 87) begin
            send_noise($urandom_range(1, 6));
         end else begin
            send_broken();
         end
         spent += sent_bytes - mark;
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // stop offering, wait for every predicted result, then let the pipeline empty
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_delimiters(input logic [7:0] h, input logic [7:0] t);
      csr_we    <= 1'b1;
      csr_index <= CSR_HEAD;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= CSR_TAIL;
      csr_wdata <= t;
      @(posedge clock);
      csr_we    <= 1'b0;
      head_reg = h;
      tail_reg = t;
      board.load_delimiters(h, t);
   endtask

   // main sequence
   initial begin
      logic [7:0] same;
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // extremes of the byte while hunting
      send_byte(8'h00);
      send_byte(8'hFF);
      // bad length from a nonzero high byte, then from a low byte just past the maximum
      send_byte(head_reg);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(head_reg);
      send_byte(8'h5A);
      send_byte(8'h00);
      send_byte(8'(MAX_PAYLOAD + 1));
      // zero length good frame, then crc and tail both wrong
      send_frame(8'hFF, 0, '0, FL_NONE);
      send_frame(8'h01, 1, 64'hFF, FL_BOTH);

      random_traffic(PHASE_BYTES);

      drain();
      set_delimiters(8'h00, 8'hFF);
      // long receiver hold while the sender streams results back to back
      hold_request = 1'b1;
      tx_steady    = 1'b1;
      repeat (16) send_frame(8'($urandom_range(0, 255)), 0, '0, FL_LEN_LSB);
      tx_steady    = 1'b0;
      random_traffic(PHASE_BYTES);

      drain();
      set_delimiters(8'hFF, 8'h00);
      random_traffic(PHASE_BYTES);

      drain();
      set_delimiters(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_traffic(PHASE_BYTES);

      // head and tail share one value
      drain();
      same = 8'($urandom_range(0, 255));
      set_delimiters(same, same);
      random_traffic(PHASE_BYTES);

      drain();
      set_delimiters(DEFAULT_HEAD, DEFAULT_TAIL);
      random_traffic(PHASE_BYTES);

      drain();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
